// File: src/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and codes for the indexed list store: operation and status
// codes, field widths and the control word of the pointer step unit.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 5;
  localparam int DATA_W = 32;
  localparam int ST_W   = 2;
  localparam int LEN_W  = 5;

  localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [OP_W-1:0] OP_ERASE   = 3'd2;
  localparam logic [OP_W-1:0] OP_REVERSE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic dec;
    logic use_sum;
  } step_ctrl_t;

endpackage

// File: src/ils_ram.sv
// ----------------------------------------------------------------------------
// ils_ram
// Generic single-write, single-read RAM with a registered, enabled read port.
// ----------------------------------------------------------------------------
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/ils_step.sv
// ----------------------------------------------------------------------------
// ils_step
// Shared pointer unit: one increment or decrement and one unsigned compare,
// reused by every loop of the sequencer.
// ----------------------------------------------------------------------------
module ils_step #(
  parameter int W = 5
) (
  input  logic [W-1:0]        x,
  input  logic [W-1:0]        a,
  input  logic [W-1:0]        b,
  input  ils_pkg::step_ctrl_t ctrl,
  output logic [W-1:0]        sum,
  output logic                lt
);

  logic [W-1:0] lhs;

  assign sum = ctrl.dec ? (x - W'(1)) : (x + W'(1));
  assign lhs = ctrl.use_sum ? sum : a;
  assign lt  = lhs < b;

endmodule

// File: src/indexed_list_store_core.sv
// ----------------------------------------------------------------------------
// indexed_list_store_core
// Fixed-capacity ordered list of signed 32-bit words held in one RAM, with
// append, insert, erase, reverse, read and clear driven by a small sequencer.
// Append, clear, reverse of fewer than two entries and rejected operations
// answer straight from idle; read waits for the registered RAM port; insert
// and erase shift one entry at a time, and reverse swaps one pair at a time,
// through the single RAM port pair.
// One transaction at a time; busy is high while the sequencer runs.
// Each result is strobed for one cycle by out_valid; the receiver cannot stall.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_store_core #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic        [ils_pkg::OP_W-1:0]     in_op,
  input  logic        [ils_pkg::IDX_W-1:0]    in_index,
  input  logic signed [ils_pkg::DATA_W-1:0]   in_value,
  output logic                                out_valid,
  output logic signed [ils_pkg::DATA_W-1:0]   out_read_data,
  output logic        [ils_pkg::ST_W-1:0]     out_status,
  output logic        [ils_pkg::LEN_W-1:0]    out_length
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > ils_pkg::IDX_W) ? CW : ils_pkg::IDX_W;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);
  localparam logic [XW-1:0] TWO_X = XW'(2);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SHIFT_RD = 4'd1;
  localparam logic [3:0] S_SHIFT_WR = 4'd2;
  localparam logic [3:0] S_COMMIT   = 4'd3;
  localparam logic [3:0] S_REV_RDA  = 4'd4;
  localparam logic [3:0] S_REV_RDB  = 4'd5;
  localparam logic [3:0] S_REV_WRA  = 4'd6;
  localparam logic [3:0] S_REV_WRB  = 4'd7;
  localparam logic [3:0] S_READ     = 4'd8;

  logic [3:0]                     state_r, state_nxt;
  logic [XW-1:0]                  count_r, count_nxt;
  logic [XW-1:0]                  ptr_r, ptr_nxt;
  logic [XW-1:0]                  ptr2_r, ptr2_nxt;
  logic [XW-1:0]                  idx_r, idx_nxt;
  logic [ils_pkg::OP_W-1:0]       op_r, op_nxt;
  logic [ils_pkg::DATA_W-1:0]     val_r, val_nxt;
  logic [ils_pkg::DATA_W-1:0]     tmp_r, tmp_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [ils_pkg::DATA_W-1:0]     out_data_r, out_data_nxt;
  logic [ils_pkg::ST_W-1:0]       out_status_r, out_status_nxt;
  logic [ils_pkg::LEN_W-1:0]      out_length_r;

  logic                           accept;
  logic [XW-1:0]                  idx_x;

  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr;
  logic [ils_pkg::DATA_W-1:0]     mem_wdata;
  logic                           mem_re;
  logic [AW-1:0]                  mem_raddr;
  logic [ils_pkg::DATA_W-1:0]     mem_rdata;

  logic [XW-1:0]                  u_x, u_a, u_b, u_sum;
  ils_pkg::step_ctrl_t            u_ctrl;
  logic                           u_lt;

  ils_ram #(
    .WIDTH (ils_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ils_step #(
    .W (XW)
  ) u_step (
    .x    (u_x),
    .a    (u_a),
    .b    (u_b),
    .ctrl (u_ctrl),
    .sum  (u_sum),
    .lt   (u_lt)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign idx_x  = XW'(in_index);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    ptr2_nxt       = ptr2_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    tmp_nxt        = tmp_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = '0;
    out_status_nxt = ils_pkg::ST_OK;
    mem_we         = 1'b0;
    mem_waddr      = ptr_r[AW-1:0];
    mem_wdata      = mem_rdata;
    mem_re         = 1'b0;
    mem_raddr      = ptr_r[AW-1:0];
    u_x            = count_r;
    u_a            = ptr_r;
    u_b            = ptr2_r;
    u_ctrl.dec     = 1'b0;
    u_ctrl.use_sum = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        u_ctrl.dec = (in_op == ils_pkg::OP_REVERSE);
        if (accept) begin
          idx_nxt = idx_x;
          op_nxt  = in_op;
          val_nxt = in_value;
          unique case (in_op)
            ils_pkg::OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (count_r == CAP_X) begin
                out_status_nxt = ils_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_value;
                count_nxt = u_sum;
              end
            end
            ils_pkg::OP_INSERT: begin
              if (idx_x > count_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ils_pkg::ST_RANGE;
              end else if (count_r == CAP_X) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ils_pkg::ST_FULL;
              end else begin
                ptr_nxt   = count_r;
                state_nxt = S_SHIFT_RD;
              end
            end
            ils_pkg::OP_ERASE: begin
              if (idx_x >= count_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ils_pkg::ST_RANGE;
              end else begin
                ptr_nxt   = idx_x;
                state_nxt = S_SHIFT_RD;
              end
            end
            ils_pkg::OP_REVERSE: begin
              if (count_r < TWO_X) begin
                out_valid_nxt = 1'b1;
              end else begin
                ptr_nxt   = '0;
                ptr2_nxt  = u_sum;
                state_nxt = S_REV_RDA;
              end
            end
            ils_pkg::OP_READ: begin
              if (idx_x >= count_r) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ils_pkg::ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = idx_x[AW-1:0];
                state_nxt = S_READ;
              end
            end
            ils_pkg::OP_CLEAR: begin
              out_valid_nxt = 1'b1;
              count_nxt     = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SHIFT_RD: begin
        u_x            = ptr_r;
        u_ctrl.dec     = (op_r == ils_pkg::OP_INSERT);
        u_ctrl.use_sum = (op_r == ils_pkg::OP_ERASE);
        u_a            = idx_r;
        u_b            = (op_r == ils_pkg::OP_INSERT) ? ptr_r : count_r;
        if (u_lt) begin
          mem_re    = 1'b1;
          mem_raddr = u_sum[AW-1:0];
          ptr2_nxt  = u_sum;
          state_nxt = S_SHIFT_WR;
        end else begin
          if (op_r == ils_pkg::OP_INSERT) begin
            mem_we    = 1'b1;
            mem_waddr = idx_r[AW-1:0];
            mem_wdata = val_r;
          end
          state_nxt = S_COMMIT;
        end
      end
      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        mem_wdata = mem_rdata;
        ptr_nxt   = ptr2_r;
        state_nxt = S_SHIFT_RD;
      end
      S_COMMIT: begin
        u_x           = count_r;
        u_ctrl.dec    = (op_r == ils_pkg::OP_ERASE);
        count_nxt     = u_sum;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_REV_RDA: begin
        u_a = ptr_r;
        u_b = ptr2_r;
        if (u_lt) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_r[AW-1:0];
          state_nxt = S_REV_RDB;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_REV_RDB: begin
        mem_re    = 1'b1;
        mem_raddr = ptr2_r[AW-1:0];
        tmp_nxt   = mem_rdata;
        state_nxt = S_REV_WRA;
      end
      S_REV_WRA: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        mem_wdata = mem_rdata;
        u_x       = ptr_r;
        ptr_nxt   = u_sum;
        state_nxt = S_REV_WRB;
      end
      S_REV_WRB: begin
        mem_we     = 1'b1;
        mem_waddr  = ptr2_r[AW-1:0];
        mem_wdata  = tmp_r;
        u_x        = ptr2_r;
        u_ctrl.dec = 1'b1;
        ptr2_nxt   = u_sum;
        state_nxt  = S_REV_RDA;
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = mem_rdata;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    ptr2_r <= ptr2_nxt;
    idx_r  <= idx_nxt;
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    tmp_r  <= tmp_nxt;
    if (out_valid_nxt) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
      out_length_r <= count_nxt[ils_pkg::LEN_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_status    = out_status_r;
  assign out_length    = out_length_r;

endmodule
